// File: rtl/ddm_pkg.sv
// ============================================================================
// ddm_pkg: differential drive mixer package
// Shared types and constants for the mixer pipeline and its register file.
// ============================================================================
package ddm_pkg;

    // Pipeline depth: 2 heading stages plus 5 motor stages
    localparam int STAGES = 7;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register reset values
    localparam logic [7:0] MAX_SPEED_RST = 8'd255;
    localparam logic [7:0] MIN_SPEED_RST = 8'd30;

    // Mapped PWM values below this floor become zero
    localparam logic signed [10:0] PWM_FLOOR = 11'sd30;

    // x/45 for x < 2^14: (x * 11651) >> 19
    localparam logic [13:0] DIV45_RECIP = 14'd11651;
    localparam int          DIV45_SHIFT = 19;

    // x/255 for x < 2^16: (x * 32897) >> 23
    localparam logic [15:0] DIV255_RECIP = 16'd32897;
    localparam int          DIV255_SHIFT = 23;

    typedef enum logic
    {
        REG_MAX_SPEED = 1'b0,
        REG_MIN_SPEED = 1'b1
    } reg_idx_t;

    // Heading curve in units of 17/3: magnitude 0..45 and sign
    typedef struct packed
    {
        logic [5:0] mag;
        logic       pos;
    } curve_t;

    // Range mapping derived from the registers
    typedef struct packed
    {
        logic signed [9:0] lo;    // min_speed - 1
        logic signed [9:0] diff;  // max_speed - lo
    } map_cfg_t;

endpackage

// File: rtl/ddm_if.sv
// ============================================================================
// ddm_if: mixer stream interfaces
// Valid/ready channels for the command words and the motor result words.
// ============================================================================
interface ddm_in_if;
    logic              valid;
    logic              ready;
    logic [7:0]        speed;
    logic signed [9:0] heading;

    modport source (output valid, output speed, output heading, input ready);
    modport sink   (input valid, input speed, input heading, output ready);
endinterface

interface ddm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] left_pwm;
    logic       left_reverse;
    logic [7:0] right_pwm;
    logic       right_reverse;

    modport source (output valid, output left_pwm, output left_reverse,
                    output right_pwm, output right_reverse, input ready);
    modport sink   (input valid, input left_pwm, input left_reverse,
                    input right_pwm, input right_reverse, output ready);
endinterface

// File: rtl/ddm_cfg.sv
// ============================================================================
// ddm_cfg: mixer register file
// APB-style speed limit registers and the derived range mapping terms.
// ============================================================================
module ddm_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ddm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ddm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ddm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output ddm_pkg::map_cfg_t               map_cfg
);
    import ddm_pkg::*;

    logic [7:0] max_speed_reg;
    logic [7:0] min_speed_reg;
    logic       wr_en;
    reg_idx_t   idx;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg <= MAX_SPEED_RST;
            min_speed_reg <= MIN_SPEED_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MAX_SPEED: max_speed_reg <= pwdata[7:0];
                REG_MIN_SPEED: min_speed_reg <= pwdata[7:0];
                default:       max_speed_reg <= max_speed_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MAX_SPEED: prdata = {24'd0, max_speed_reg};
            REG_MIN_SPEED: prdata = {24'd0, min_speed_reg};
            default:       prdata = '0;
        endcase
    end

    // Registers are to change only while the pipeline is empty; the block does not enforce this, so no staging here
    assign map_cfg.lo   = $signed({2'b00, min_speed_reg}) - 10'sd1;
    assign map_cfg.diff = $signed({2'b00, max_speed_reg}) - map_cfg.lo;

endmodule

// File: rtl/ddm_heading.sv
// ============================================================================
// ddm_heading: heading front end
// Two stages: reduce the heading to 0..359, then evaluate both motor curves.
// ============================================================================
module ddm_heading
(
    input  logic              clk,
    input  logic              en,
    input  logic [7:0]        speed,
    input  logic signed [9:0] heading,
    output logic [7:0]        spd,
    output ddm_pkg::curve_t   crv_left,
    output ddm_pkg::curve_t   crv_right
);
    import ddm_pkg::*;

    // Curves in units of 17/3 degrees of slope; plateaus at +-45
    function automatic curve_t eval_curve(input logic [8:0] r, input logic right);
        logic signed [9:0] rs;
        logic signed [9:0] c;
        logic signed [9:0] cm;
        curve_t            res;
        rs = $signed({1'b0, r});
        if (!right)
        begin
            if (r <= 9'd90)       c = 10'sd45;
            else if (r <= 9'd180) c = 10'sd135 - rs;
            else if (r <= 9'd270) c = -10'sd45;
            else                  c = rs - 10'sd315;
        end
        else
        begin
            if (r <= 9'd90)       c = rs - 10'sd45;
            else if (r <= 9'd180) c = 10'sd45;
            else if (r <= 9'd270) c = 10'sd225 - rs;
            else                  c = -10'sd45;
        end
        cm      = -c;
        res.mag = c[9] ? cm[5:0] : c[5:0];
        res.pos = !c[9] && (c != 10'sd0);
        return res;
    endfunction

    logic signed [10:0] d;
    logic signed [10:0] d_neg;
    logic [9:0]         a;
    logic [8:0]         r_next;
    logic [8:0]         r_reg;
    logic [7:0]         spd1_reg;
    logic [7:0]         spd2_reg;
    curve_t             crv_left_reg;
    curve_t             crv_right_reg;

    // |heading + 360| mod 360, at most two subtractions
    always_comb
    begin
        d     = 11'(heading) + 11'sd360;
        d_neg = -d;
        a     = d[10] ? d_neg[9:0] : d[9:0];
        if (a >= 10'd720)      r_next = 9'(a - 10'd720);
        else if (a >= 10'd360) r_next = 9'(a - 10'd360);
        else                   r_next = a[8:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg         <= r_next;
            spd1_reg      <= speed;
            spd2_reg      <= spd1_reg;
            crv_left_reg  <= eval_curve(r_reg, 1'b0);
            crv_right_reg <= eval_curve(r_reg, 1'b1);
        end
    end

    assign spd       = spd2_reg;
    assign crv_left  = crv_left_reg;
    assign crv_right = crv_right_reg;

endmodule

// File: rtl/ddm_motor.sv
// ============================================================================
// ddm_motor: one motor channel
// Five stages: speed scaling, divide by 45, range multiply, divide by 255,
// offset and floor.
// ============================================================================
module ddm_motor
(
    input  logic              clk,
    input  logic              en,
    input  logic [7:0]        spd,
    input  ddm_pkg::curve_t   crv,
    input  ddm_pkg::map_cfg_t map_cfg,
    output logic [7:0]        pwm,
    output logic              reverse
);
    import ddm_pkg::*;

    logic [13:0]        p_next;
    logic [13:0]        p_reg;
    logic [27:0]        m45;
    logic [7:0]         mag_reg;
    logic signed [18:0] prod_next;
    logic signed [18:0] prod_reg;
    logic signed [18:0] prod_neg;
    logic [15:0]        a;
    logic [31:0]        m255;
    logic [8:0]         q_reg;
    logic               neg_reg;
    logic signed [10:0] qs;
    logic signed [10:0] v;
    logic [7:0]         pwm_next;
    logic [7:0]         pwm_reg;
    logic               rev3_reg;
    logic               rev4_reg;
    logic               rev5_reg;
    logic               rev6_reg;
    logic               rev7_reg;

    // speed * |curve|; |scaled curve| = this / 45
    assign p_next    = 14'(spd) * 14'(crv.mag);
    assign m45       = 28'(p_reg) * 28'(DIV45_RECIP);
    assign prod_next = 19'($signed({1'b0, mag_reg})) * 19'(map_cfg.diff);

    // Truncating divide by 255 works on the magnitude
    assign prod_neg  = -prod_reg;
    assign a         = prod_reg[18] ? prod_neg[15:0] : prod_reg[15:0];
    assign m255      = 32'(a) * 32'(DIV255_RECIP);

    always_comb
    begin
        qs       = neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
        v        = qs + 11'(map_cfg.lo);
        pwm_next = (v < PWM_FLOOR) ? 8'd0 : v[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= p_next;
            rev3_reg <= crv.pos && (spd != 8'd0);
            mag_reg  <= m45[DIV45_SHIFT +: 8];
            rev4_reg <= rev3_reg;
            prod_reg <= prod_next;
            rev5_reg <= rev4_reg;
            q_reg    <= m255[DIV255_SHIFT +: 9];
            neg_reg  <= prod_reg[18];
            rev6_reg <= rev5_reg;
            pwm_reg  <= pwm_next;
            rev7_reg <= rev6_reg;
        end
    end

    assign pwm     = pwm_reg;
    assign reverse = rev7_reg;

endmodule

// File: rtl/differential_drive_mixer_unit.sv
// ============================================================================
// differential_drive_mixer_unit: differential drive mixer
// Speed and heading in, left and right motor PWM and direction out.
// ============================================================================
//
//   port      dir   role
//   -------   ---   -----------------------------------------------
//   in_ch     in    command word: speed, heading
//   out_ch    out   result word: left/right pwm and reverse bits
//   apb       in    max_speed at 0x0, min_speed at 0x4
//
// Seven register stages, one word per cycle while the output word is taken.
// The whole pipeline advances on one enable: it stalls only when the output
// register holds a word that is not taken. Bubbles are not squeezed out.
// Reset clears the valid bits and loads max_speed 255, min_speed 30.
//
module differential_drive_mixer_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    ddm_in_if.sink                          in_ch,
    ddm_out_if.source                       out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ddm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ddm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ddm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import ddm_pkg::*;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic              pipe_en;
    logic [7:0]        spd;
    curve_t            crv_left;
    curve_t            crv_right;
    map_cfg_t          map_cfg;

    assign pipe_en     = !valid_reg[STAGES-1] || out_ch.ready;
    assign in_ch.ready = pipe_en;
    assign valid_next  = {valid_reg[STAGES-2:0], in_ch.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (pipe_en)
        begin
            valid_reg <= valid_next;
        end
    end

    ddm_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .map_cfg (map_cfg)
    );

    ddm_heading u_heading
    (
        .clk       (clk),
        .en        (pipe_en),
        .speed     (in_ch.speed),
        .heading   (in_ch.heading),
        .spd       (spd),
        .crv_left  (crv_left),
        .crv_right (crv_right)
    );

    ddm_motor u_left
    (
        .clk     (clk),
        .en      (pipe_en),
        .spd     (spd),
        .crv     (crv_left),
        .map_cfg (map_cfg),
        .pwm     (out_ch.left_pwm),
        .reverse (out_ch.left_reverse)
    );

    ddm_motor u_right
    (
        .clk     (clk),
        .en      (pipe_en),
        .spd     (spd),
        .crv     (crv_right),
        .map_cfg (map_cfg),
        .pwm     (out_ch.right_pwm),
        .reverse (out_ch.right_reverse)
    );

    assign out_ch.valid = valid_reg[STAGES-1];

`ifndef SYNTHESIS
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> valid_reg[0])
        else $error("accepted word did not enter the pipeline");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(valid_reg))
        else $error("pipeline moved during a stall");

    a_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.left_pwm == 8'd0 || out_ch.left_pwm >= 8'd30)
                      && (out_ch.right_pwm == 8'd0 || out_ch.right_pwm >= 8'd30))
        else $error("pwm below floor not cleared");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[STAGES-1] |-> in_ch.ready)
        else $error("input blocked with empty output register");
`endif

endmodule
